FILE: rtl/swmt_pkg.sv
// ----------------------------------------------------------------------------
// swmt_pkg: shared types and microcode for the sliding window max tracker
// Holds the sample width, the sequencer step codes, the jump conditions and
// the control store that drives the datapath.
// ----------------------------------------------------------------------------
package swmt_pkg;

   // sample and peak width
   localparam int SAMPLE_W = 16;

   // sequencer step addresses
   typedef enum logic [2:0] {
      ST_IDLE       = 3'd0,
      ST_WRITE      = 3'd1,
      ST_SCAN_ISSUE = 3'd2,
      ST_SCAN_LOOP  = 3'd3,
      ST_FINISH     = 3'd4
   } step_type;

   // jump conditions evaluated by the sequencer
   typedef enum logic [2:0] {
      COND_ALWAYS    = 3'd0,
      COND_REQ_VALID = 3'd1,
      COND_NEED_SCAN = 3'd2,
      COND_SCAN_MORE = 3'd3,
      COND_RSP_FREE  = 3'd4
   } cond_type;

   // one control word
   typedef struct packed {
      logic     req_ready;     // accept a transaction
      logic     mem_write;     // write sample into the ring
      logic     peak_update;   // new peak or rescan start
      logic     scan_read;     // issue a ring read, advance scan slot
      logic     scan_compare;  // compare read data against the peak
      logic     rsp_load;      // load the output register, advance write slot
      cond_type cond;
      step_type next_true;
      step_type next_false;
   } ucode_type;

   // control store
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type uw;
      uw = '{req_ready: 1'b0, mem_write: 1'b0, peak_update: 1'b0, scan_read: 1'b0,
             scan_compare: 1'b0, rsp_load: 1'b0, cond: COND_ALWAYS,
             next_true: ST_IDLE, next_false: ST_IDLE};
      unique case (step)
         ST_IDLE: begin
            uw.req_ready  = 1'b1;
            uw.cond       = COND_REQ_VALID;
            uw.next_true  = ST_WRITE;
            uw.next_false = ST_IDLE;
         end
         ST_WRITE: begin
            uw.mem_write   = 1'b1;
            uw.peak_update = 1'b1;
            uw.cond        = COND_NEED_SCAN;
            uw.next_true   = ST_SCAN_ISSUE;
            uw.next_false  = ST_FINISH;
         end
         ST_SCAN_ISSUE: begin
            uw.scan_read  = 1'b1;
            uw.cond       = COND_ALWAYS;
            uw.next_true  = ST_SCAN_LOOP;
            uw.next_false = ST_SCAN_LOOP;
         end
         ST_SCAN_LOOP: begin
            uw.scan_read    = 1'b1;
            uw.scan_compare = 1'b1;
            uw.cond         = COND_SCAN_MORE;
            uw.next_true    = ST_SCAN_LOOP;
            uw.next_false   = ST_FINISH;
         end
         ST_FINISH: begin
            uw.rsp_load   = 1'b1;
            uw.cond       = COND_RSP_FREE;
            uw.next_true  = ST_IDLE;
            uw.next_false = ST_FINISH;
         end
         default: begin
            uw.cond       = COND_ALWAYS;
            uw.next_true  = ST_IDLE;
            uw.next_false = ST_IDLE;
         end
      endcase
      return uw;
   endfunction

endpackage

FILE: rtl/swmt_if.sv
// ----------------------------------------------------------------------------
// swmt_if: valid/ready channels of the sliding window max tracker
// Request channel carries one sample per transaction, response channel one
// window peak per transaction.
// ----------------------------------------------------------------------------
interface swmt_req_if;
   logic                         valid;
   logic                         ready;
   logic [swmt_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swmt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [swmt_pkg::SAMPLE_W-1:0] window_peak;

   modport source (output valid, output window_peak, input ready);
   modport sink   (input valid, input window_peak, output ready);
endinterface

FILE: rtl/sliding_window_max_tracker.sv
// ----------------------------------------------------------------------------
// sliding_window_max_tracker: peak of the last WINDOW_DEPTH samples
// Microcoded sequencer over a ring memory, a running peak and a rescan loop.
// ----------------------------------------------------------------------------
// Each request transaction carries one 16-bit sample; the block writes it into
// a ring of WINDOW_DEPTH slots and returns one response holding the largest
// sample in the ring. The ring reads as zero after reset: a fill count marks
// the slots written so far, so there is no clearing pass and the block takes
// requests right after reset. A sample goes through accept, write and respond
// unless it overwrites the slot holding the peak with a smaller value; then the
// whole ring is rescanned through the single read port of the ring memory, one
// slot per cycle, before the respond step. One sample is processed at a time;
// the response sits in an output register, so the next request is accepted
// while the previous response waits.
// ----------------------------------------------------------------------------
module sliding_window_max_tracker #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   swmt_req_if.sink    req_port,
   swmt_rsp_if.source  rsp_port
);
   import swmt_pkg::*;

   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);

   // sequencer
   step_type  step_ff, step_in;
   ucode_type uw;
   logic      cond_ok;

   // datapath registers
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [AW-1:0]       wp_ff, wp_in;
   logic [SAMPLE_W-1:0] peak_val_ff, peak_val_in;
   logic [AW-1:0]       peak_pos_ff, peak_pos_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [AW-1:0]       scan_slot_ff, scan_slot_in;
   logic [CW-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [AW-1:0]       cmp_slot_ff, cmp_slot_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_peak_ff, rsp_peak_in;

   // ring memory
   logic [SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];

   logic                req_take;
   logic                need_scan;
   logic                scan_more;
   logic                rd_en;
   logic                mem_we;
   logic                rsp_free;
   logic [SAMPLE_W-1:0] rd_val;

   // control word fetch and status
   always_comb begin
      uw        = ucode_rom(step_ff);
      req_take  = uw.req_ready && req_port.valid;
      need_scan = (sample_ff < peak_val_ff) && (wp_ff == peak_pos_ff);
      scan_more = (scan_cnt_ff < FULL_CNT);
      rd_en     = uw.scan_read && scan_more;
      mem_we    = uw.mem_write;
      rsp_free  = !rsp_valid_ff || rsp_port.ready;
      rd_val    = rd_ok_ff ? rd_data_ff : '0;
   end

   // jump condition and next step
   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS:    cond_ok = 1'b1;
         COND_REQ_VALID: cond_ok = req_port.valid;
         COND_NEED_SCAN: cond_ok = need_scan;
         COND_SCAN_MORE: cond_ok = scan_more;
         COND_RSP_FREE:  cond_ok = rsp_free;
         default:        cond_ok = 1'b1;
      endcase
      step_in = cond_ok ? uw.next_true : uw.next_false;
   end

   // datapath next values
   always_comb begin
      sample_in    = sample_ff;
      wp_in        = wp_ff;
      peak_val_in  = peak_val_ff;
      peak_pos_in  = peak_pos_ff;
      fill_in      = fill_ff;
      scan_slot_in = scan_slot_ff;
      scan_cnt_in  = scan_cnt_ff;
      cmp_slot_in  = cmp_slot_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_peak_in  = rsp_peak_ff;

      if (req_take) begin
         sample_in = req_port.sample;
      end

      // ring write counts toward the fill level
      if (mem_we && (fill_ff != FULL_CNT)) begin
         fill_in = fill_ff + 1'b1;
      end

      // new peak, or start of a rescan from zero at the write slot
      if (uw.peak_update) begin
         if (sample_ff >= peak_val_ff) begin
            peak_val_in = sample_ff;
            peak_pos_in = wp_ff;
         end else if (need_scan) begin
            peak_val_in  = '0;
            peak_pos_in  = wp_ff;
            scan_slot_in = wp_ff;
            scan_cnt_in  = '0;
         end
      end

      // compare the slot read in the previous cycle, later slot wins a tie
      if (uw.scan_compare && (rd_val >= peak_val_ff)) begin
         peak_val_in = rd_val;
         peak_pos_in = cmp_slot_ff;
      end

      // issue the next ring read
      if (rd_en) begin
         cmp_slot_in  = scan_slot_ff;
         rd_ok_in     = (fill_ff == FULL_CNT) || (CW'(scan_slot_ff) < fill_ff);
         scan_slot_in = (scan_slot_ff == LAST_SLOT) ? '0 : scan_slot_ff + 1'b1;
         scan_cnt_in  = scan_cnt_ff + 1'b1;
      end

      // output register
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (uw.rsp_load && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_peak_in  = peak_val_ff;
         wp_in        = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         wp_ff        <= '0;
         peak_val_ff  <= '0;
         peak_pos_ff  <= '0;
         fill_ff      <= '0;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         wp_ff        <= wp_in;
         peak_val_ff  <= peak_val_in;
         peak_pos_ff  <= peak_pos_in;
         fill_ff      <= fill_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      scan_slot_ff <= scan_slot_in;
      cmp_slot_ff  <= cmp_slot_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_peak_ff  <= rsp_peak_in;
   end

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wp_ff] <= sample_ff;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[scan_slot_ff];
      end
   end

   // ports
   assign req_port.ready       = uw.req_ready;
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.window_peak = rsp_peak_ff;

   // checks
   a_accept_then_write: assert property (@(posedge clock) disable iff (reset)
      req_take |=> step_ff == ST_WRITE)
      else $error("accepted transaction not followed by ring write");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= FULL_CNT)
      else $error("rescan read count overran the ring");

   a_fill_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fill_ff >= $past(fill_ff))
      else $error("fill level decreased");

   a_peak_slot_range: assert property (@(posedge clock) disable iff (reset)
      (peak_pos_ff <= LAST_SLOT) && (wp_ff <= LAST_SLOT))
      else $error("slot index out of ring range");

endmodule

FILE: test/sliding_window_max_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_max_tracker_tb: self-checking bench for the window peak tracker
// A directed table and shaped random sample bursts are sent through the request
// channel. A ring copy kept in the bench predicts each window peak, and every
// response transaction is checked in order. Random idle gaps are applied on the
// request channel, random and forced back-pressure on the response channel.
// ----------------------------------------------------------------------------
module sliding_window_max_tracker_tb;
   import swmt_pkg::*;

   localparam int RING_DEPTH      = 256;
   localparam int RANDOM_ITEMS    = 600;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int SETTLE_CYCLES   = RING_DEPTH + 16;
   localparam int WATCHDOG_LIMIT  = 8 * (HOLD_OFF_CYCLES + RING_DEPTH);
   localparam int DIRECTED_ROWS   = 16;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // shapes of the random sample bursts
   typedef enum int {
      PAT_UNIFORM,
      PAT_FEW_LEVELS,
      PAT_FALLING,
      PAT_RISING,
      PAT_EXTREMES,
      PAT_SPIKE
   } burst_kind_type;

   // one row of the directed table; peak is only used where known is set
   typedef struct packed {
      sample_type sample;
      logic       known;
      sample_type peak;
   } directed_row_type;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'h0000, 1'b1, 16'h0000},   // reset zeros in the window
      '{16'h0005, 1'b1, 16'h0005},
      '{16'h0003, 1'b1, 16'h0005},
      '{16'h0005, 1'b1, 16'h0005},   // tie takes the newer slot
      '{16'hFFFF, 1'b1, 16'hFFFF},
      '{16'h0000, 1'b1, 16'hFFFF},
      '{16'hFFFE, 1'b1, 16'hFFFF},
      '{16'h8000, 1'b0, 16'h0000},
      '{16'h7FFF, 1'b0, 16'h0000},
      '{16'h0001, 1'b0, 16'h0000},
      '{16'hAAAA, 1'b0, 16'h0000},
      '{16'h5555, 1'b0, 16'h0000},
      '{16'h0000, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b1, 16'hFFFF},
      '{16'h00FF, 1'b0, 16'h0000},
      '{16'hFF00, 1'b0, 16'h0000}
   };

   logic clock = 1'b0;
   logic reset;

   swmt_req_if req_bus ();
   swmt_rsp_if rsp_bus ();

   // ring copy and running peak of the predictor
   sample_type  ring_copy [RING_DEPTH];
   int unsigned next_slot_pos = 0;
   int unsigned peak_slot     = 0;
   sample_type  peak_level    = '0;
   sample_type  window_peak_queue [$];

   // burst generator state; the run opens with a long falling ramp so the
   // peak slot gets overwritten early
   burst_kind_type burst_kind = PAT_FALLING;
   int             burst_left = 300;
   int unsigned    ramp_level = 32'h0000_F000;

   int req_idle_pct   = 15;
   int rsp_idle_pct   = 81;
   bit hold_off_start = 1'b0;
   int mismatches     = 0;

   sliding_window_max_tracker #(
      .WINDOW_DEPTH(RING_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // write one sample into the ring copy and return the peak of the window
   function automatic sample_type track_window_peak(input sample_type s);
      int unsigned slot;
      int unsigned n;
      int unsigned best_slot;
      sample_type  best;
      ring_copy[next_slot_pos] = s;
      if (s >= peak_level) begin
         peak_level = s;
         peak_slot  = next_slot_pos;
      end else if (next_slot_pos == peak_slot) begin
         // peak slot lost to a smaller sample: rescan from the write slot,
         // wrapping, from zero; later slots win ties
         best      = '0;
         best_slot = next_slot_pos;
         slot      = next_slot_pos;
         for (n = 0; n < RING_DEPTH; n++) begin
            if (ring_copy[slot] >= best) begin
               best      = ring_copy[slot];
               best_slot = slot;
            end
            slot = (slot + 1) % RING_DEPTH;
         end
         peak_level = best;
         peak_slot  = best_slot;
      end
      next_slot_pos = (next_slot_pos + 1) % RING_DEPTH;
      return peak_level;
   endfunction

   // next sample of the current random burst, picking a new burst when done
   function automatic sample_type next_burst_sample();
      int unsigned step;
      sample_type  s;
      if (burst_left == 0) begin
         burst_kind = burst_kind_type'($urandom_range(0, 5));
         burst_left = $urandom_range(16, 320);
         ramp_level = $urandom_range(0, 16'hFFFF);
         if (burst_kind == PAT_SPIKE) begin
            ramp_level = $urandom_range(16'h8000, 16'hFFFF);
         end
      end
      burst_left--;
      step = $urandom_range(0, 3);
      case (burst_kind)
         PAT_FEW_LEVELS: begin
            // four levels only: many ties in the rescan
            s = sample_type'($urandom_range(0, 3) * 16'h5555);
         end
         PAT_FALLING: begin
            ramp_level = (ramp_level > step) ? ramp_level - step : 0;
            s          = sample_type'(ramp_level);
         end
         PAT_RISING: begin
            ramp_level = (ramp_level + step > 16'hFFFF) ? 16'hFFFF : ramp_level + step;
            s          = sample_type'(ramp_level);
         end
         PAT_EXTREMES: begin
            case ($urandom_range(0, 3))
               0:       s = 16'h0000;
               1:       s = 16'h0001;
               2:       s = 16'hFFFE;
               default: s = 16'hFFFF;
            endcase
         end
         PAT_SPIKE: begin
            // rare spikes over a lower floor
            s = ($urandom_range(0, 63) == 0) ? sample_type'(ramp_level)
                                             : sample_type'($urandom_range(0, ramp_level - 1));
         end
         default: begin
            s = sample_type'($urandom_range(0, 16'hFFFF));
         end
      endcase
      return s;
   endfunction

   // offer one sample, wait for the transaction, queue its expected peak
   task automatic send_sample(input sample_type s, input logic known, input sample_type peak);
      sample_type predicted;
      while ($urandom_range(1, 100) <= req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) begin
         @(posedge clock);
      end
      predicted = track_window_peak(s);
      window_peak_queue.push_back(known ? peak : predicted);
   endtask

   // stimulus: reset, directed table, then three phases of random bursts
   initial begin : stimulus
      int n;
      int phase;
      for (n = 0; n < RING_DEPTH; n++) begin
         ring_copy[n] = '0;
      end
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         send_sample(directed_rows[n].sample, directed_rows[n].known, directed_rows[n].peak);
      end

      for (phase = 0; phase < 3; phase++) begin
         // sender pauses until every expected peak has come back
         req_bus.valid <= 1'b0;
         do begin
            @(posedge clock);
         end while (window_peak_queue.size() != 0);
         case (phase)
            0: begin
               req_idle_pct = 15;
               rsp_idle_pct = 81;
            end
            1: begin
               req_idle_pct = 81;
               rsp_idle_pct = 15;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
            // long receiver hold-off while samples keep coming
            if (phase == 2 && n == 20) begin
               hold_off_start = 1'b1;
            end
            send_sample(next_burst_sample(), 1'b0, '0);
         end
      end

      // drain and let any stray response show up
      req_bus.valid <= 1'b0;
      while (window_peak_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // response ready: random stalls, plus one counted hold-off on request
   initial begin : drive_response_ready
      int hold_left;
      bit hold_done;
      hold_left     = 0;
      hold_done     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_start && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(1, 100) > rsp_idle_pct);
         end
      end
   end

   // compare each response transaction with the oldest expected peak
   always @(posedge clock) begin
      sample_type expected_peak;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (window_peak_queue.size() == 0) begin
            $display("%0t: window_peak expected none, actual %h", $time, rsp_bus.window_peak);
            mismatches++;
         end else begin
            expected_peak = window_peak_queue.pop_front();
            if (rsp_bus.window_peak !== expected_peak) begin
               $display("%0t: window_peak expected %h, actual %h",
                        $time, expected_peak, rsp_bus.window_peak);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long without any transaction on either channel
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

endmodule
